/* rtl/least_loaded_list_scheduler_top_defines.svh */
// Assertion macros shared by the scheduler RTL.
`ifndef LEAST_LOADED_LIST_SCHEDULER_TOP_DEFINES_SVH
`define LEAST_LOADED_LIST_SCHEDULER_TOP_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define LLLS_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("scheduler check failed");

// The consequent must hold in the cycle after the antecedent.
`define LLLS_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("scheduler check failed");

`endif

/* rtl/llls_pkg.sv */
package llls_pkg;

    localparam int SEL_W   = 6;
    localparam int CNT_W   = 7;
    localparam int TIME_W  = 16;
    localparam int ID_W    = 8;
    localparam int CFG_W   = 4;
    localparam int MS_W    = 24;
    localparam int TOTAL_W = 32;
    localparam int MACH_W  = 3;

    typedef struct packed
    {
        logic              add;
        logic              clear;
        logic [SEL_W-1:0]  sel;
        logic [TIME_W-1:0] amount;
        logic [CNT_W-1:0]  active;
    } cell_cmd_t;

    typedef struct packed
    {
        logic             tok;
        logic             found;
        logic [SEL_W-1:0] pick;
    } sweep_t;

    typedef enum logic [2:0]
    {
        ST_IDLE = 3'b001,
        ST_SCAN = 3'b010,
        ST_DONE = 3'b100
    } state_t;

    function automatic logic [63:0] sat_add(input logic [63:0] load,
                                            input logic [TIME_W-1:0] amount,
                                            input logic [63:0] limit);
        logic [64:0] sum;
        sum = {1'b0, load} + 65'(amount);
        if (sum > {1'b0, limit})
        begin
            return limit;
        end
        return sum[63:0];
    endfunction

endpackage

/* rtl/llls_cell.sv */
module llls_cell
    import llls_pkg::*;
#(
    parameter int INDEX     = 0,
    parameter int LOAD_BITS = 24
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  cell_cmd_t            cmd,
    input  sweep_t               ctl_in,
    input  logic [LOAD_BITS-1:0] min_in,
    input  logic [LOAD_BITS-1:0] max_in,
    output sweep_t               ctl_out,
    output logic [LOAD_BITS-1:0] min_out,
    output logic [LOAD_BITS-1:0] max_out
);

    localparam logic [63:0] LOAD_MAX = {{(64-LOAD_BITS){1'b0}}, {LOAD_BITS{1'b1}}};

    logic [LOAD_BITS-1:0] load_reg;
    logic [LOAD_BITS-1:0] load_next;
    logic                 tok_reg;
    logic                 found_reg;
    logic [SEL_W-1:0]     pick_reg;
    logic [LOAD_BITS-1:0] min_reg;
    logic [LOAD_BITS-1:0] max_reg;
    logic                 in_use;
    logic                 take;

    assign in_use = CNT_W'(INDEX) < cmd.active;
    assign take   = in_use && (!ctl_in.found || (load_reg < min_in));

    always_comb
    begin
        load_next = load_reg;
        if (cmd.clear)
        begin
            load_next = '0;
        end
        else if (cmd.add && (cmd.sel == SEL_W'(INDEX)))
        begin
            load_next = LOAD_BITS'(sat_add(64'(load_reg), cmd.amount, LOAD_MAX));
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            load_reg <= '0;
            tok_reg  <= 1'b0;
        end
        else
        begin
            load_reg <= load_next;
            tok_reg  <= ctl_in.tok;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl_in.tok)
        begin
            found_reg <= ctl_in.found | in_use;
            pick_reg  <= take ? SEL_W'(INDEX) : ctl_in.pick;
            min_reg   <= take ? load_reg : min_in;
            max_reg   <= (load_reg > max_in) ? load_reg : max_in;
        end
    end

    assign ctl_out.tok   = tok_reg;
    assign ctl_out.found = found_reg;
    assign ctl_out.pick  = pick_reg;
    assign min_out       = min_reg;
    assign max_out       = max_reg;

endmodule

/* rtl/least_loaded_list_scheduler_top.sv */
// Each request is one job (or a bare group or evaluation marker). A sweep token walks a
// row of MACHINES cells, one cell per cycle, each comparing its load against the running
// minimum and maximum. After the token leaves the last cell the scheduler moves from SCAN
// to DONE, commits the result into the output register and returns to IDLE, the only state
// in which the next request can be accepted; the length of the cell row sets the rate.
// A finished result waits in the output register while the next request is taken, and
// the next result is held back, with the input stalled, until that register is read.
`include "least_loaded_list_scheduler_top_defines.svh"

module least_loaded_list_scheduler_top
    import llls_pkg::*;
#(
    parameter int MACHINES  = 8,
    parameter int LOAD_BITS = 24
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             cfg_valid,
    output logic             cfg_ready,
    input  logic [CFG_W-1:0] cfg_data,      // machines_in_use
    input  logic             s_axis_tvalid,
    output logic             s_axis_tready,
    input  logic [23:0]      s_axis_tdata,  // job_time, job_id
    input  logic             s_axis_tlast,  // end_of_group
    input  logic [1:0]       s_axis_tuser,  // has_job, end_of_evaluation
    output logic             m_axis_tvalid,
    input  logic             m_axis_tready,
    output logic [103:0]     m_axis_tdata,  // assigned_machine, echoed_job_id,
                                            // group_makespan, running_total, best_total
    output logic [1:0]       m_axis_tuser   // job_assigned, best_improved
);

    localparam logic [63:0] LOAD_MAX = {{(64-LOAD_BITS){1'b0}}, {LOAD_BITS{1'b1}}};

    state_t               state_reg;
    state_t               state_next;
    logic [CFG_W-1:0]     cfg_reg;
    logic [TIME_W-1:0]    time_reg;
    logic [ID_W-1:0]      id_reg;
    logic                 has_job_reg;
    logic                 close_reg;
    logic                 eval_reg;
    logic [TOTAL_W-1:0]   total_reg;
    logic [TOTAL_W-1:0]   total_next;
    logic [TOTAL_W-1:0]   best_reg;
    logic [TOTAL_W-1:0]   best_next;
    logic                 out_valid_reg;
    logic                 out_valid_next;
    logic [103:0]         out_data_reg;
    logic [1:0]           out_user_reg;

    logic                 accept;
    logic                 commit;
    logic [CNT_W-1:0]     count;
    cell_cmd_t            cmd;
    sweep_t               ctl [MACHINES+1];
    logic [LOAD_BITS-1:0] mn  [MACHINES+1];
    logic [LOAD_BITS-1:0] mx  [MACHINES+1];
    logic [LOAD_BITS-1:0] new_load;
    logic [LOAD_BITS-1:0] makespan;
    logic [63:0]          sum;
    logic [TOTAL_W-1:0]   total_mid;
    logic                 improved;

    assign cfg_ready     = 1'b1;
    assign s_axis_tready = state_reg == ST_IDLE;
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign commit        = (state_reg == ST_DONE) && (!out_valid_reg || m_axis_tready);

    always_comb
    begin
        count = (cfg_reg == '0) ? CNT_W'(1) : CNT_W'(cfg_reg);
        if (count > CNT_W'(MACHINES))
        begin
            count = CNT_W'(MACHINES);
        end
    end

    assign cmd.add    = commit && has_job_reg;
    assign cmd.clear  = commit && close_reg;
    assign cmd.sel    = ctl[MACHINES].pick;
    assign cmd.amount = time_reg;
    assign cmd.active = count;

    assign ctl[0].tok   = accept;
    assign ctl[0].found = 1'b0;
    assign ctl[0].pick  = '0;
    assign mn[0]        = '0;
    assign mx[0]        = '0;

    for (genvar i = 0; i < MACHINES; i++)
    begin : g_cell
        llls_cell #(
            .INDEX     (i),
            .LOAD_BITS (LOAD_BITS)
        ) u_cell (
            .clk     (clk),
            .rst_n   (rst_n),
            .cmd     (cmd),
            .ctl_in  (ctl[i]),
            .min_in  (mn[i]),
            .max_in  (mx[i]),
            .ctl_out (ctl[i+1]),
            .min_out (mn[i+1]),
            .max_out (mx[i+1])
        );
    end

    always_comb
    begin
        new_load = LOAD_BITS'(sat_add(64'(mn[MACHINES]), time_reg, LOAD_MAX));
        makespan = mx[MACHINES];
        if (has_job_reg && (new_load > makespan))
        begin
            makespan = new_load;
        end
        if (!close_reg)
        begin
            makespan = '0;
        end
        sum       = 64'(total_reg) + 64'(makespan);
        total_mid = (sum > 64'(32'hFFFF_FFFF)) ? '1 : sum[TOTAL_W-1:0];
        improved  = eval_reg && (total_mid < best_reg);
        best_next = improved ? total_mid : best_reg;
        total_next = eval_reg ? '0 : total_mid;
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                if (ctl[MACHINES].tok)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (commit)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (commit)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_axis_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            cfg_reg       <= CFG_W'(7);
            total_reg     <= '0;
            best_reg      <= '1;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            if (cfg_valid && cfg_ready)
            begin
                cfg_reg <= cfg_data;
            end
            if (commit)
            begin
                total_reg <= total_next;
                best_reg  <= best_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            time_reg    <= s_axis_tdata[15:0];
            id_reg      <= s_axis_tdata[23:16];
            has_job_reg <= s_axis_tuser[0];
            close_reg   <= s_axis_tlast | s_axis_tuser[1];
            eval_reg    <= s_axis_tuser[1];
        end
        if (commit)
        begin
            out_data_reg <= {5'b0, best_next, total_mid, MS_W'(makespan), id_reg,
                             has_job_reg ? ctl[MACHINES].pick[MACH_W-1:0] : MACH_W'(0)};
            out_user_reg <= {improved, has_job_reg};
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;
    assign m_axis_tuser  = out_user_reg;

    `LLLS_ASSERT_NEXT(a_accept_starts_scan, accept, state_reg == ST_SCAN)
    `LLLS_ASSERT_NOW(a_sweep_end_in_scan, ctl[MACHINES].tok, state_reg == ST_SCAN)
    `LLLS_ASSERT_NOW(a_pick_in_use, commit && has_job_reg, CNT_W'(ctl[MACHINES].pick) < count)
    `LLLS_ASSERT_NEXT(a_best_never_rises, commit, best_reg <= $past(best_reg))

endmodule

/* test/testbench.sv */
`timescale 1ns / 100ps

module testbench;
    import llls_pkg::*;

    localparam int MACHINE_SLOTS = 8;
    localparam int CYCLE_LIMIT   = 150000;
    localparam int DRAIN_CYCLES  = 24;

    typedef struct packed
    {
        logic [TIME_W-1:0] job_time;
        logic [ID_W-1:0]   job_id;
        logic              has_job;
        logic              group_end;
        logic              eval_end;
    } job_req_t;

    typedef struct packed
    {
        logic [MACH_W-1:0]  machine;
        logic [ID_W-1:0]    job_id;
        logic               assigned;
        logic [MS_W-1:0]    makespan;
        logic [TOTAL_W-1:0] total;
        logic [TOTAL_W-1:0] best;
        logic               improved;
    } sched_result_t;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               cfg_valid = 1'b0;
    logic               cfg_ready;
    logic [CFG_W-1:0]   cfg_data = '0;
    logic               s_axis_tvalid = 1'b0;
    logic               s_axis_tready;
    logic [23:0]        s_axis_tdata = '0;
    logic               s_axis_tlast = 1'b0;
    logic [1:0]         s_axis_tuser = '0;
    logic               m_axis_tvalid;
    logic               m_axis_tready = 1'b0;
    logic [103:0]       m_axis_tdata;
    logic [1:0]         m_axis_tuser;

    job_req_t           job_requests[$];
    sched_result_t      scheduled_results[$];
    job_req_t           offered_job;

    logic [MS_W-1:0]    machine_loads[MACHINE_SLOTS];
    logic [TOTAL_W-1:0] eval_sum = '0;
    logic [TOTAL_W-1:0] best_sum = '1;
    logic [CFG_W-1:0]   machines_cfg = 4'd7;

    int                 requests_queued = 0;
    int                 requests_accepted = 0;
    int                 results_checked = 0;
    int                 evaluations_closed = 0;
    int                 improvements = 0;
    int                 error_count = 0;
    int                 cycle_count = 0;
    int                 hold_left = 0;
    bit                 holdoff_done = 1'b0;

    least_loaded_list_scheduler_top dut
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_data      (cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    initial
    begin
        foreach (machine_loads[k])
        begin
            machine_loads[k] = '0;
        end
    end

    // Assigns one request to the least loaded machine and closes groups and evaluations.
    function automatic sched_result_t schedule_request(job_req_t req);
        int               count;
        int               pick;
        logic [MS_W-1:0]  lowest;
        logic [MS_W-1:0]  peak;
        logic [MS_W:0]    load_sum;
        logic [TOTAL_W:0] total_sum;
        sched_result_t    res;
        count = machines_cfg;
        if (count == 0)
        begin
            count = 1;
        end
        if (count > MACHINE_SLOTS)
        begin
            count = MACHINE_SLOTS;
        end
        pick = 0;
        peak = '0;
        res = '0;
        if (req.has_job)
        begin
            lowest = machine_loads[0];
            for (int k = 1; k < count; k++)
            begin
                if (machine_loads[k] < lowest)
                begin
                    lowest = machine_loads[k];
                    pick = k;
                end
            end
            load_sum = {1'b0, machine_loads[pick]} + req.job_time;
            machine_loads[pick] = load_sum[MS_W] ? '1 : load_sum[MS_W-1:0];
        end
        if (req.group_end || req.eval_end)
        begin
            foreach (machine_loads[k])
            begin
                if (machine_loads[k] > peak)
                begin
                    peak = machine_loads[k];
                end
                machine_loads[k] = '0;
            end
            total_sum = {1'b0, eval_sum} + peak;
            eval_sum = total_sum[TOTAL_W] ? '1 : total_sum[TOTAL_W-1:0];
        end
        res.total = eval_sum;
        if (req.eval_end)
        begin
            evaluations_closed++;
            if (eval_sum < best_sum)
            begin
                best_sum = eval_sum;
                res.improved = 1'b1;
                improvements++;
            end
            eval_sum = '0;
        end
        res.machine = req.has_job ? MACH_W'(pick) : '0;
        res.job_id = req.job_id;
        res.assigned = req.has_job;
        res.makespan = peak;
        res.best = best_sum;
        return res;
    endfunction

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("least_loaded_list_scheduler_top test failed");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (s_axis_tvalid && s_axis_tready)
            begin
                scheduled_results.insert(scheduled_results.size(),
                                         schedule_request(offered_job));
                requests_accepted++;
            end
            if (!s_axis_tvalid || s_axis_tready)
            begin
                if (job_requests.size() > 0 &&
                    ((requests_accepted >= 300 && requests_accepted < 400) ||
                     $urandom_range(99) >= 28))
                begin
                    offered_job = job_requests.pop_front();
                    s_axis_tvalid <= 1'b1;
                    s_axis_tdata <= {offered_job.job_id, offered_job.job_time};
                    s_axis_tlast <= offered_job.group_end;
                    s_axis_tuser <= {offered_job.eval_end, offered_job.has_job};
                end
                else
                begin
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        sched_result_t got;
        sched_result_t want;
        if (rst_n)
        begin
            if (m_axis_tvalid && m_axis_tready)
            begin
                got.machine = m_axis_tdata[2:0];
                got.job_id = m_axis_tdata[10:3];
                got.makespan = m_axis_tdata[34:11];
                got.total = m_axis_tdata[66:35];
                got.best = m_axis_tdata[98:67];
                got.assigned = m_axis_tuser[0];
                got.improved = m_axis_tuser[1];
                if (scheduled_results.size() == 0)
                begin
                    error_count++;
                    $display("%0t: unexpected result machine=%0d id=%h total=%h", $time,
                             got.machine, got.job_id, got.total);
                end
                else
                begin
                    want = scheduled_results.pop_front();
                    results_checked++;
                    if (got !== want)
                    begin
                        error_count++;
                        $display("%0t: mismatch expected mach=%0d id=%h asg=%b span=%h",
                                 $time, want.machine, want.job_id, want.assigned,
                                 want.makespan, " total=%h best=%h impr=%b",
                                 want.total, want.best, want.improved);
                        $display("%0t:          actual   mach=%0d id=%h asg=%b span=%h",
                                 $time, got.machine, got.job_id, got.assigned,
                                 got.makespan, " total=%h best=%h impr=%b",
                                 got.total, got.best, got.improved);
                    end
                end
            end
            if (results_checked == 150 && !holdoff_done)
            begin
                hold_left = 300;
                holdoff_done = 1'b1;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                m_axis_tready <= 1'b0;
            end
            else
            begin
                m_axis_tready <= (results_checked >= 300 && results_checked < 400) ||
                                 ($urandom_range(99) >= 28);
            end
        end
    end

    task automatic queue_request(input logic [TIME_W-1:0] job_time, input logic [ID_W-1:0] id,
                                 input logic has_job, input logic group_end,
                                 input logic eval_end);
        job_req_t req;
        req.job_time = job_time;
        req.job_id = id;
        req.has_job = has_job;
        req.group_end = group_end;
        req.eval_end = eval_end;
        job_requests.insert(job_requests.size(), req);
        requests_queued++;
    endtask

    task automatic write_machine_count(input logic [CFG_W-1:0] value);
        while (!(requests_accepted == requests_queued && scheduled_results.size() == 0))
        begin
            @(posedge clk);
        end
        repeat (DRAIN_CYCLES) @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_data <= value;
        do
        begin
            @(posedge clk);
        end
        while (!cfg_ready);
        machines_cfg = value;
        cfg_valid <= 1'b0;
    endtask

    function automatic logic [TIME_W-1:0] random_job_time();
        int unsigned mode;
        mode = $urandom_range(99);
        if (mode < 60)
        begin
            return TIME_W'($urandom_range(255));
        end
        if (mode < 85)
        begin
            return TIME_W'($urandom);
        end
        return mode[0] ? '1 : '0;
    endfunction

    // Mostly well-formed evaluations of a few groups, with bare markers and
    // evaluation ends that arrive without a group end mixed in.
    task automatic queue_random_evaluations(input int budget);
        int target;
        int groups;
        int jobs;
        bit last_group;
        target = requests_queued + budget;
        while (requests_queued < target)
        begin
            groups = $urandom_range(1, 3);
            for (int g = 0; g < groups; g++)
            begin
                last_group = (g == groups - 1);
                jobs = $urandom_range(0, 8);
                for (int j = 0; j < jobs; j++)
                begin
                    if ($urandom_range(99) < 8)
                    begin
                        queue_request(TIME_W'($urandom), ID_W'($urandom), 1'b0, 1'b0, 1'b0);
                    end
                    if (j == jobs - 1)
                    begin
                        if (last_group && $urandom_range(3) == 0)
                        begin
                            queue_request(random_job_time(), ID_W'($urandom), 1'b1,
                                          1'b0, 1'b1);
                        end
                        else
                        begin
                            queue_request(random_job_time(), ID_W'($urandom), 1'b1, 1'b1,
                                          last_group && $urandom_range(1) == 1);
                        end
                    end
                    else
                    begin
                        queue_request(random_job_time(), ID_W'($urandom), 1'b1, 1'b0, 1'b0);
                    end
                end
                if (jobs == 0)
                begin
                    queue_request(TIME_W'($urandom), ID_W'($urandom), 1'b0, 1'b1, last_group);
                end
            end
            if (job_requests[$].eval_end == 1'b0)
            begin
                queue_request(TIME_W'($urandom), ID_W'($urandom), 1'b0,
                              1'($urandom_range(1)), 1'b1);
            end
        end
    endtask

    initial
    begin
        logic [CFG_W-1:0] random_counts[5];
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        // Reset machine count of seven, ties and both field extremes.
        queue_request('0, '0, 1'b0, 1'b0, 1'b0);
        queue_request('0, '0, 1'b1, 1'b0, 1'b0);
        queue_request('1, '1, 1'b1, 1'b0, 1'b0);
        for (int k = 1; k <= 5; k++)
        begin
            queue_request(TIME_W'(k), ID_W'(8'h10 + k), 1'b1, 1'b0, 1'b0);
        end
        queue_request(16'd10, 8'h5a, 1'b1, 1'b0, 1'b0);
        queue_request(16'd3, 8'ha5, 1'b1, 1'b1, 1'b0);
        queue_request(16'd77, 8'h33, 1'b0, 1'b0, 1'b1);
        queue_request(16'd100, 8'h44, 1'b1, 1'b0, 1'b1);
        queue_request(16'd100, 8'h55, 1'b1, 1'b1, 1'b1);

        // The group stays open across the count change, so machines left out
        // of use still carry load into the makespan.
        write_machine_count(4'd8);
        for (int k = 0; k < 7; k++)
        begin
            queue_request(16'd1, ID_W'(8'h80 + k), 1'b1, 1'b0, 1'b0);
        end
        queue_request(16'hffff, 8'h87, 1'b1, 1'b0, 1'b0);
        write_machine_count(4'd0);
        queue_request(16'd5, 8'hc0, 1'b1, 1'b0, 1'b0);
        queue_request(16'd7, 8'hc1, 1'b1, 1'b1, 1'b0);
        write_machine_count(4'd15);
        queue_request(16'd1, 8'hf0, 1'b1, 1'b1, 1'b1);

        // One machine and near-maximum times drive its load into saturation.
        write_machine_count(4'd1);
        for (int k = 0; k < 258; k++)
        begin
            queue_request(TIME_W'($urandom_range(65000, 65535)), ID_W'($urandom), 1'b1,
                          k == 257, k == 257);
        end

        random_counts[0] = 4'd2;
        random_counts[1] = 4'd8;
        random_counts[2] = 4'd5;
        random_counts[3] = 4'd15;
        random_counts[4] = CFG_W'($urandom_range(0, 15));
        foreach (random_counts[p])
        begin
            write_machine_count(random_counts[p]);
            queue_random_evaluations(50);
        end

        while (!(requests_accepted == requests_queued && scheduled_results.size() == 0))
        begin
            @(posedge clk);
        end
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Checked %0d results from %0d requests over %0d evaluations (%0d improved).",
                 results_checked, requests_accepted, evaluations_closed, improvements);
        $display("Machine counts 0, 1, 2, 5, 7, 8 and 15 were used, with load saturation.");
        if (error_count == 0)
        begin
            $display("least_loaded_list_scheduler_top test passed");
        end
        else
        begin
            $display("least_loaded_list_scheduler_top test failed");
        end
        $finish;
    end

endmodule

/* sim.f */
+incdir+rtl
rtl/llls_pkg.sv
rtl/llls_cell.sv
rtl/least_loaded_list_scheduler_top.sv
test/testbench.sv
